[design/fgpe_pkg.sv]
// fgpe_pkg: shared types and constants of the font glyph pixel expander
// used by fgpe_addr_gen and font_glyph_pixel_expander; no dependencies
`default_nettype none

package fgpe_pkg;

   // request kinds
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_DRAW = 1'b1;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_GLYPH_WIDTH  = 1'b0,
      CSR_GLYPH_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [5:0] GLYPH_WIDTH_RESET  = 6'd8;
   localparam logic [5:0] GLYPH_HEIGHT_RESET = 6'd16;

   // first code held in the font (space)
   localparam logic [7:0] FIRST_CODE = 8'd32;

   // byte address math: (223 * 63 * 4 + 31 * 4 + 4) fits in 17 bits
   localparam int BASE_W = 17;
   localparam int PROD_W = 14;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR1,
      ST_ADDR2,
      ST_READ,
      ST_LOAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic stage_a;
      logic stage_b;
   } addr_ctl_type;

   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic              bad;
   } addr_res_type;

endpackage

`default_nettype wire

[design/fgpe_addr_gen.sv]
// fgpe_addr_gen: two-step row byte address and range check
// depends on fgpe_pkg
`default_nettype none

module fgpe_addr_gen #(
   parameter int FONT_BYTES = 4096
) (
   input  wire                   clock,
   input  wire fgpe_pkg::addr_ctl_type ctl,
   input  wire  [7:0]            char_code,
   input  wire  [4:0]            row_index,
   input  wire  [5:0]            glyph_height,
   input  wire  [2:0]            row_bytes,
   output fgpe_pkg::addr_res_type res
);

   logic [fgpe_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                        code_ok_ff, code_ok_in;
   logic                        row_ok_ff, row_ok_in;
   logic [fgpe_pkg::BASE_W-1:0] base_ff, base_in;
   logic [fgpe_pkg::BASE_W-1:0] end_addr;
   logic                        bad_ff, bad_in;
   logic [7:0]                  code_off;

   // step one: glyph offset in rows
   always_comb begin
      code_off   = char_code - fgpe_pkg::FIRST_CODE;
      code_ok_in = (char_code >= fgpe_pkg::FIRST_CODE);
      row_ok_in  = ({1'b0, row_index} < glyph_height);
      prod_in    = fgpe_pkg::PROD_W'(code_off) * fgpe_pkg::PROD_W'(glyph_height);
   end

   // step two: scale by row bytes, add row offset, check the row end
   always_comb begin
      base_in  = fgpe_pkg::BASE_W'(prod_ff) * fgpe_pkg::BASE_W'(row_bytes)
               + fgpe_pkg::BASE_W'(row_index) * fgpe_pkg::BASE_W'(row_bytes);
      end_addr = base_in + fgpe_pkg::BASE_W'(row_bytes);
      bad_in   = !code_ok_ff || !row_ok_ff || (32'(end_addr) > FONT_BYTES);
   end

   always_ff @(posedge clock) begin
      if (ctl.stage_a) begin
         prod_ff    <= prod_in;
         code_ok_ff <= code_ok_in;
         row_ok_ff  <= row_ok_in;
      end
      if (ctl.stage_b) begin
         base_ff <= base_in;
         bad_ff  <= bad_in;
      end
   end

   assign res.base = base_ff;
   assign res.bad  = bad_ff;

endmodule

`default_nettype wire

[design/font_glyph_pixel_expander.sv]
// font_glyph_pixel_expander: bitmap font character generator, top level
// depends on fgpe_pkg and fgpe_addr_gen
// load: store written at the transfer edge; busy stays low, next request the following cycle
// draw: busy through ADDR1, ADDR2, READ, LOAD and EMIT; pixels start once EMIT is reached,
//   then one pixel per cycle until the last column; the two-step address unit and the
//   registered font store read lie between the transfer and the first pixel
// reset: glyph_width 8, glyph_height 16, idle; font store not cleared
`default_nettype none

module font_glyph_pixel_expander #(
   parameter int FONT_BYTES      = 4096,
   parameter int MAX_GLYPH_WIDTH = 32
) (
   input  wire         clock,
   input  wire         reset,
   // request side
   input  wire         start,
   output logic        busy,
   input  wire         req_action,
   input  wire  [11:0] req_load_addr,
   input  wire  [7:0]  req_load_byte,
   input  wire  [7:0]  req_char_code,
   input  wire  [4:0]  req_row_index,
   input  wire  [15:0] req_bg_color,
   input  wire  [15:0] req_fg_color,
   // pixel side, one transfer per cycle of rsp_valid
   output logic        rsp_valid,
   output logic [15:0] rsp_pixel_color,
   output logic [4:0]  rsp_column,
   output logic        rsp_last_pixel,
   output logic        rsp_bad_request,
   // configuration writes
   input  wire         csr_we,
   input  wire  [0:0]  csr_index,
   input  wire  [5:0]  csr_wdata
);

   localparam int ADDR_W      = $clog2(FONT_BYTES);
   localparam int GLYPH_LIMIT = (MAX_GLYPH_WIDTH < 32) ? MAX_GLYPH_WIDTH : 32;

   // configuration registers
   logic [5:0] glyph_width_ff;
   logic [5:0] glyph_height_ff;

   // effective width and bytes per glyph row
   logic [5:0] width_eff;
   logic [2:0] row_bytes;
   logic [6:0] width_round;

   always_comb begin
      priority if (glyph_width_ff == 6'd0) begin
         width_eff = 6'd1;
      end else if (glyph_width_ff > 6'(GLYPH_LIMIT)) begin
         width_eff = 6'(GLYPH_LIMIT);
      end else begin
         width_eff = glyph_width_ff;
      end
      width_round = 7'(width_eff) + 7'd7;
      row_bytes   = width_round[5:3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_width_ff  <= fgpe_pkg::GLYPH_WIDTH_RESET;
         glyph_height_ff <= fgpe_pkg::GLYPH_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (fgpe_pkg::csr_index_type'(csr_index))
            fgpe_pkg::CSR_GLYPH_WIDTH:  glyph_width_ff  <= csr_wdata;
            fgpe_pkg::CSR_GLYPH_HEIGHT: glyph_height_ff <= csr_wdata;
         endcase
      end
   end

   // request transfer
   logic take;
   logic take_load;
   logic take_draw;

   assign take      = start && !busy;
   assign take_load = take && (req_action == fgpe_pkg::ACT_LOAD);
   assign take_draw = take && (req_action == fgpe_pkg::ACT_DRAW);

   // captured draw request
   logic [7:0]  code_ff;
   logic [4:0]  row_ff;
   logic [15:0] bg_ff;
   logic [15:0] fg_ff;

   always_ff @(posedge clock) begin
      if (take_draw) begin
         code_ff <= req_char_code;
         row_ff  <= req_row_index;
         bg_ff   <= req_bg_color;
         fg_ff   <= req_fg_color;
      end
   end

   // sequencer
   fgpe_pkg::state_type     state_ff, state_in;
   fgpe_pkg::addr_ctl_type  addr_ctl;
   fgpe_pkg::addr_res_type  addr_res;
   logic [4:0]              col_ff, col_in;
   logic [7:0]              bits_ff, bits_in;
   logic [7:0]              rd_data_ff;
   logic [2:0]              rd_offset;
   logic                    col_last;
   logic [5:0]              width_last;

   assign width_last = width_eff - 6'd1;
   assign col_last   = ({1'b0, col_ff} == width_last);

   always_comb begin
      state_in         = state_ff;
      addr_ctl.stage_a = 1'b0;
      addr_ctl.stage_b = 1'b0;
      rd_offset        = 3'd0;
      col_in           = col_ff;
      bits_in          = bits_ff;
      unique case (state_ff)
         fgpe_pkg::ST_IDLE: begin
            if (take_draw) begin
               state_in = fgpe_pkg::ST_ADDR1;
            end
         end
         fgpe_pkg::ST_ADDR1: begin
            addr_ctl.stage_a = 1'b1;
            state_in         = fgpe_pkg::ST_ADDR2;
         end
         fgpe_pkg::ST_ADDR2: begin
            addr_ctl.stage_b = 1'b1;
            state_in         = fgpe_pkg::ST_READ;
         end
         fgpe_pkg::ST_READ: begin
            // first row byte
            rd_offset = 3'd0;
            state_in  = fgpe_pkg::ST_LOAD;
         end
         fgpe_pkg::ST_LOAD: begin
            // first byte arrives, second byte requested
            rd_offset = 3'd1;
            bits_in   = rd_data_ff;
            col_in    = 5'd0;
            state_in  = fgpe_pkg::ST_EMIT;
         end
         fgpe_pkg::ST_EMIT: begin
            // keep the byte after the current one in the read register
            rd_offset = 3'(col_ff[4:3]) + 3'd1;
            if (col_last) begin
               state_in = fgpe_pkg::ST_IDLE;
            end else begin
               col_in = col_ff + 5'd1;
               if (col_ff[2:0] == 3'd7) begin
                  bits_in = rd_data_ff;
               end else begin
                  bits_in = {bits_ff[6:0], 1'b0};
               end
            end
         end
         default: begin
            state_in = fgpe_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fgpe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff  <= col_in;
      bits_ff <= bits_in;
   end

   fgpe_addr_gen #(
      .FONT_BYTES (FONT_BYTES)
   ) u_addr_gen (
      .clock        (clock),
      .ctl          (addr_ctl),
      .char_code    (code_ff),
      .row_index    (row_ff),
      .glyph_height (glyph_height_ff),
      .row_bytes    (row_bytes),
      .res          (addr_res)
   );

   // font store, one write and one registered read per cycle
   logic [7:0]                  font_mem [FONT_BYTES];
   logic [fgpe_pkg::BASE_W-1:0] rd_addr;
   logic [fgpe_pkg::BASE_W-1:0] wr_addr;
   logic                        wr_in_range;

   assign rd_addr     = addr_res.base + fgpe_pkg::BASE_W'(rd_offset);
   assign wr_addr     = fgpe_pkg::BASE_W'(req_load_addr);
   assign wr_in_range = (32'(req_load_addr) < FONT_BYTES);

   always_ff @(posedge clock) begin
      if (take_load && wr_in_range) begin
         font_mem[wr_addr[ADDR_W-1:0]] <= req_load_byte;
      end
      // reads past the row end only fill the lookahead and are never shown
      rd_data_ff <= font_mem[rd_addr[ADDR_W-1:0]];
   end

   // outputs
   assign busy            = (state_ff != fgpe_pkg::ST_IDLE);
   assign rsp_valid       = (state_ff == fgpe_pkg::ST_EMIT);
   assign rsp_column      = col_ff;
   assign rsp_last_pixel  = col_last;
   assign rsp_bad_request = addr_res.bad;
   // msb of the shifting byte is the current column's bit
   assign rsp_pixel_color = (!addr_res.bad && bits_ff[7]) ? fg_ff : bg_ff;

   // checks
   a_col_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_pixel |=>
         rsp_valid && (rsp_column == 5'($past(rsp_column) + 5'd1)))
      else $error("pixel columns not consecutive");

   a_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_pixel |=> !rsp_valid)
      else $error("pixel transfer after last pixel");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_column} < width_eff))
      else $error("column beyond glyph width");

   a_draw_starts: assert property (@(posedge clock) disable iff (reset)
      take_draw |=> busy && !rsp_valid)
      else $error("draw request not started");

   a_load_no_pixel: assert property (@(posedge clock) disable iff (reset)
      take_load |=> !busy && !rsp_valid)
      else $error("load request produced activity");

endmodule

`default_nettype wire
